>>> rtl/itf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter package
// Shared widths, register and conversion codes, ASCII constants, the
// configuration struct and the digit to character function.
// ----------------------------------------------------------------------------
package itf_pkg;

    localparam int VALUE_W          = 64;
    localparam int HALF_W           = VALUE_W / 2;
    localparam int BCD_W            = 80;   // 20 decimal digits
    localparam int DIGIT_W          = 4;
    localparam int CHAR_W           = 8;
    localparam int FW_W             = 7;
    localparam int POS_W            = 8;    // character position within one run
    localparam int CFG_DATA_W       = 7;
    localparam int CFG_IDX_W        = 3;
    localparam int DEF_OUTPUT_LIMIT = 64;
    localparam int DEF_MAX_DIGITS   = 64;

    // Conversion codes. Codes above CONV_BIN behave as unsigned decimal.
    localparam logic [2:0] CONV_SDEC = 3'd0;
    localparam logic [2:0] CONV_UDEC = 3'd1;
    localparam logic [2:0] CONV_OCT  = 3'd2;
    localparam logic [2:0] CONV_HEX  = 3'd3;
    localparam logic [2:0] CONV_BIN  = 3'd4;

    // Sign modes. The unused code behaves as SIGN_NEG_ONLY.
    localparam logic [1:0] SIGN_NEG_ONLY = 2'd0;
    localparam logic [1:0] SIGN_PLUS     = 2'd1;
    localparam logic [1:0] SIGN_SPACE    = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CONVERSION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_VALUE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIGN_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_ZERO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_BEFORE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_PREFIX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_HEX   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MIN   = 3'd7;

    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef struct packed {
        logic [2:0]      conversion;
        logic            wide_value;
        logic [1:0]      sign_mode;
        logic            pad_zero;
        logic            pad_before;
        logic            show_prefix;
        logic            upper_hex;
        logic [FW_W-1:0] width_min;
    } itf_cfg_t;

    localparam itf_cfg_t CFG_RESET = '{
        conversion:  CONV_SDEC,
        wide_value:  1'b0,
        sign_mode:   SIGN_NEG_ONLY,
        pad_zero:    1'b0,
        pad_before:  1'b1,
        show_prefix: 1'b0,
        upper_hex:   1'b0,
        width_min:   '0
    };

    typedef struct packed {
        logic done;      // digit store complete for the current value
        logic negative;  // value takes a minus sign
    } itf_gen_status_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < 4'd10) begin
            return CH_ZERO + d_ext;
        end
        return (upper ? CH_UPPER_A : CH_LOWER_A) + d_ext - 8'd10;
    endfunction

endpackage

>>> rtl/itf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module itf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/itf_digit_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Digit generator
// Turns one value into digits, least significant first, written to the
// digit store one per cycle. Decimal goes through a bit-serial double
// dabble pass first; power-of-two bases are split directly.
// ----------------------------------------------------------------------------
module itf_digit_gen #(
    parameter int MAX_DIGITS = itf_pkg::DEF_MAX_DIGITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [itf_pkg::VALUE_W-1:0]        value,
    input  itf_pkg::itf_cfg_t                  cfg,
    output logic                               busy,
    output logic                               wr_en,
    output logic [$clog2(MAX_DIGITS)-1:0]      wr_addr,
    output logic [itf_pkg::DIGIT_W-1:0]        wr_data,
    output itf_pkg::itf_gen_status_t           status,
    output logic [$clog2(MAX_DIGITS+1)-1:0]    digit_count
);
    import itf_pkg::*;

    localparam int AW  = $clog2(MAX_DIGITS);
    localparam int CW  = $clog2(MAX_DIGITS + 1);
    localparam int BW  = $clog2(VALUE_W);
    localparam int NIB = BCD_W / DIGIT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_DABBLE, ST_SPLIT} state_t;

    state_t             state_reg, state_next;
    logic [BCD_W-1:0]   work_reg, work_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               neg_reg, neg_next;

    logic [VALUE_W-1:0] v_masked, v_ext, magnitude;
    logic               negative, decimal, finish;
    logic [BCD_W-1:0]   bcd_adj, shifted;
    logic [DIGIT_W-1:0] digit;
    logic [CW-1:0]      cnt_inc;

    always_comb begin
        v_masked = cfg.wide_value ? value : {{HALF_W{1'b0}}, value[HALF_W-1:0]};
        v_ext    = cfg.wide_value ? value
                                  : {{HALF_W{value[HALF_W-1]}}, value[HALF_W-1:0]};
        negative = (cfg.conversion == CONV_SDEC) &&
                   (cfg.wide_value ? value[VALUE_W-1] : value[HALF_W-1]);
        magnitude = negative ? (~v_ext + 1'b1) : v_masked;
        decimal   = !((cfg.conversion == CONV_OCT) || (cfg.conversion == CONV_HEX) ||
                      (cfg.conversion == CONV_BIN));
    end

    // Add-3 correction on every BCD digit before each shift.
    always_comb begin
        for (int i = 0; i < NIB; i++) begin
            if (work_reg[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = work_reg[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = work_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        unique case (cfg.conversion)
            CONV_OCT: begin
                digit   = {1'b0, work_reg[2:0]};
                shifted = work_reg >> 3;
            end
            CONV_HEX: begin
                digit   = work_reg[3:0];
                shifted = work_reg >> 4;
            end
            CONV_BIN: begin
                digit   = {3'b000, work_reg[0]};
                shifted = work_reg >> 1;
            end
            default: begin
                digit   = work_reg[3:0];
                shifted = work_reg >> 4;
            end
        endcase
    end

    assign cnt_inc = cnt_reg + 1'b1;
    assign finish  = (state_reg == ST_SPLIT) &&
                     ((shifted == '0) || (cnt_inc == CW'(MAX_DIGITS)));

    always_comb begin
        state_next   = state_reg;
        work_next    = work_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    neg_next     = negative;
                    cnt_next     = '0;
                    bit_cnt_next = '0;
                    if (decimal) begin
                        work_next  = '0;
                        bin_next   = magnitude;
                        state_next = ST_DABBLE;
                    end else begin
                        work_next  = {{(BCD_W-VALUE_W){1'b0}}, magnitude};
                        state_next = ST_SPLIT;
                    end
                end
            end
            ST_DABBLE: begin
                work_next    = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BW'(VALUE_W - 1)) begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                work_next = shifted;
                cnt_next  = cnt_inc;
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            bit_cnt_reg <= '0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            bit_cnt_reg <= bit_cnt_next;
            neg_reg     <= neg_next;
        end
        work_reg <= work_next;
        bin_reg  <= bin_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign wr_en           = (state_reg == ST_SPLIT);
    assign wr_addr         = cnt_reg[AW-1:0];
    assign wr_data         = digit;
    assign status.done     = finish;
    assign status.negative = neg_reg;
    assign digit_count     = cnt_inc;

endmodule

>>> rtl/itf_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character emitter
// Walks the character positions of one run, reads digits from the digit
// store most significant first and drives the registered output channel.
// ----------------------------------------------------------------------------
module itf_emit #(
    parameter int OUTPUT_LIMIT = itf_pkg::DEF_OUTPUT_LIMIT,
    parameter int MAX_DIGITS   = itf_pkg::DEF_MAX_DIGITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  itf_pkg::itf_cfg_t               cfg,
    input  itf_pkg::itf_gen_status_t        status,
    input  logic [$clog2(MAX_DIGITS+1)-1:0] digit_count,
    output logic                            rd_en,
    output logic [$clog2(MAX_DIGITS)-1:0]   rd_addr,
    input  logic [itf_pkg::DIGIT_W-1:0]     rd_data,
    output logic                            busy,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [itf_pkg::CHAR_W-1:0]      m_character,
    output logic                            m_last
);
    import itf_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t            state_reg;
    logic              neg_reg;
    logic              sign_len_reg;
    logic [1:0]        sx_reg;      // sign plus prefix length
    logic [POS_W-1:0]  d0_reg;      // first digit position within the body
    logic [POS_W-1:0]  top_reg;     // last digit position within the body
    logic [POS_W-1:0]  total_reg;
    logic [POS_W-1:0]  k_reg;
    logic              b_valid_reg, b_digit_reg, b_last_reg;
    logic [CHAR_W-1:0] b_char_reg;
    logic              m_valid_reg, m_last_reg;
    logic [CHAR_W-1:0] m_char_reg;

    // Run setup
    logic [POS_W-1:0] n_ext, fw_ext, pad, raw_total, prefix_len, d0;
    logic             sign_on;

    // Per position
    logic [POS_W-1:0]  j, dig_idx;
    logic              a_fire, b_advance, a_digit;
    logic [CHAR_W-1:0] a_char, fill_char, sign_char, prefix_char;

    always_comb begin
        n_ext   = {{(POS_W-CW){1'b0}}, digit_count};
        fw_ext  = {{(POS_W-FW_W){1'b0}}, cfg.width_min};
        pad     = (fw_ext > n_ext) ? (fw_ext - n_ext) : '0;
        sign_on = status.negative || (cfg.sign_mode == SIGN_PLUS) ||
                  (cfg.sign_mode == SIGN_SPACE);
        prefix_len = '0;
        if (cfg.show_prefix) begin
            unique case (cfg.conversion)
                CONV_OCT: prefix_len = 8'd1;
                CONV_HEX: prefix_len = 8'd2;
                CONV_BIN: prefix_len = 8'd1;
                default:  prefix_len = 8'd0;
            endcase
        end
        raw_total = {{(POS_W-1){1'b0}}, sign_on} + prefix_len + pad + n_ext;
        d0        = cfg.pad_before ? pad : '0;
    end

    always_comb begin
        fill_char = cfg.pad_zero ? CH_ZERO : CH_SPACE;
        sign_char = neg_reg ? CH_MINUS : ((cfg.sign_mode == SIGN_PLUS) ? CH_PLUS : CH_SPACE);
        if (cfg.conversion == CONV_BIN) begin
            prefix_char = CH_LOWER_B;
        end else if (k_reg == {{(POS_W-1){1'b0}}, sign_len_reg}) begin
            prefix_char = CH_ZERO;
        end else begin
            prefix_char = cfg.upper_hex ? CH_UPPER_X : CH_LOWER_X;
        end
        j       = k_reg - {{(POS_W-2){1'b0}}, sx_reg};
        dig_idx = top_reg - j;
        a_digit = 1'b0;
        priority if (k_reg < {{(POS_W-1){1'b0}}, sign_len_reg}) begin
            a_char = sign_char;
        end else if (k_reg < {{(POS_W-2){1'b0}}, sx_reg}) begin
            a_char = prefix_char;
        end else if ((j >= d0_reg) && (j <= top_reg)) begin
            a_char  = fill_char;
            a_digit = 1'b1;
        end else begin
            a_char = fill_char;
        end
    end

    assign b_advance = b_valid_reg && (!m_valid_reg || m_ready);
    assign a_fire    = (state_reg == ST_RUN) && (k_reg < total_reg) &&
                       (!b_valid_reg || b_advance);
    assign rd_en     = a_fire && a_digit;
    assign rd_addr   = dig_idx[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (status.done) begin
                        state_reg <= ST_RUN;
                        k_reg     <= '0;
                    end
                end
                ST_RUN: begin
                    if (a_fire) begin
                        k_reg <= k_reg + 1'b1;
                    end
                    if ((k_reg == total_reg) && !b_valid_reg) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase

            if (a_fire) begin
                b_valid_reg <= 1'b1;
            end else if (b_advance) begin
                b_valid_reg <= 1'b0;
            end

            if (b_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end

        if ((state_reg == ST_IDLE) && status.done) begin
            neg_reg      <= status.negative;
            sign_len_reg <= sign_on;
            sx_reg       <= 2'({1'b0, sign_on} + prefix_len[1:0]);
            d0_reg       <= d0;
            top_reg      <= d0 + n_ext - 1'b1;
            total_reg    <= (raw_total > POS_W'(OUTPUT_LIMIT)) ? POS_W'(OUTPUT_LIMIT)
                                                              : raw_total;
        end
        if (a_fire) begin
            b_digit_reg <= a_digit;
            b_char_reg  <= a_char;
            b_last_reg  <= (k_reg == total_reg - 1'b1);
        end
        if (b_advance) begin
            m_char_reg <= b_digit_reg ? digit_char(rd_data, cfg.upper_hex) : b_char_reg;
            m_last_reg <= b_last_reg;
        end
    end

    assign busy        = (state_reg == ST_RUN);
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

endmodule

>>> rtl/integer_to_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer to text formatter
// Formats one integer word per transaction as a run of ASCII characters
// with sign, base prefix and padding, the last character marked.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    s_value[63:0]
//  m_        out        m_valid/m_ready    m_character[7:0], m_last
//  cfg_      in         cfg_wr_en          cfg_index[2:0], cfg_wr_data[6:0]
//
//  One value is handled at a time. Decimal first runs the double dabble
//  pass, then fills the digit store one digit per cycle (up to 20); octal,
//  hex and binary fill it one digit per cycle (up to 22, 16 or 64).
//  Emission then gives one character per cycle (at most OUTPUT_LIMIT) while
//  the output does not stall, through the digit store read and the output
//  register. The next value is taken once the emitter is back in idle,
//  after the last character reaches the output register. Reset is
//  synchronous; the digit store needs no clearing. Output stalls hold the emitter in place.
// ----------------------------------------------------------------------------
module integer_to_text_formatter #(
    parameter int OUTPUT_LIMIT = itf_pkg::DEF_OUTPUT_LIMIT,
    parameter int MAX_DIGITS   = itf_pkg::DEF_MAX_DIGITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [itf_pkg::VALUE_W-1:0]     s_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [itf_pkg::CHAR_W-1:0]      m_character,
    output logic                            m_last,
    input  logic                            cfg_wr_en,
    input  logic [itf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [itf_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import itf_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    itf_cfg_t         cfg_reg;
    itf_gen_status_t  gen_status;
    logic             gen_busy, emit_busy, start;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    logic [DIGIT_W-1:0] wr_data, rd_data;
    logic [CW-1:0]    digit_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CONVERSION:  cfg_reg.conversion  <= cfg_wr_data[2:0];
                REG_WIDE_VALUE:  cfg_reg.wide_value  <= cfg_wr_data[0];
                REG_SIGN_MODE:   cfg_reg.sign_mode   <= cfg_wr_data[1:0];
                REG_PAD_ZERO:    cfg_reg.pad_zero    <= cfg_wr_data[0];
                REG_PAD_BEFORE:  cfg_reg.pad_before  <= cfg_wr_data[0];
                REG_SHOW_PREFIX: cfg_reg.show_prefix <= cfg_wr_data[0];
                REG_UPPER_HEX:   cfg_reg.upper_hex   <= cfg_wr_data[0];
                REG_WIDTH_MIN:   cfg_reg.width_min   <= cfg_wr_data[FW_W-1:0];
            endcase
        end
    end

    assign s_ready = !gen_busy && !emit_busy;
    assign start   = s_valid && s_ready;

    itf_digit_gen #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_digit_gen (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start),
        .value       (s_value),
        .cfg         (cfg_reg),
        .busy        (gen_busy),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .status      (gen_status),
        .digit_count (digit_count)
    );

    itf_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    itf_emit #(
        .OUTPUT_LIMIT (OUTPUT_LIMIT),
        .MAX_DIGITS   (MAX_DIGITS)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .status      (gen_status),
        .digit_count (digit_count),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .busy        (emit_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

>>> dv/tb_integer_to_text_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for integer_to_text_formatter
// Drives integer values through the valid/ready input channel under a range
// of register settings, predicts the ASCII run that each value should give,
// and checks every character and its last flag in order on the output side.
// Both channels idle at random; one phase holds the output off for a long
// stretch so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_integer_to_text_formatter;
    import itf_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int TEXT_LIMIT    = DEF_OUTPUT_LIMIT;
    localparam int DIGIT_LIMIT   = DEF_MAX_DIGITS;
    localparam int IDLE_PERCENT  = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [VALUE_W-1:0]    s_value     = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [CHAR_W-1:0]     m_character;
    logic                  m_last;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    itf_cfg_t   fmt_cfg;
    text_char_t expected_text[$];
    int         errors      = 0;
    int         cycle_count = 0;
    bit         idle_on     = 1'b1;
    int         hold_req    = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;

    integer_to_text_formatter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Builds the text of one value under the current settings and queues it.
    task automatic predict_text(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] radix;
        logic [DIGIT_W-1:0] digit_buf [DIGIT_LIMIT];
        logic [DIGIT_W-1:0] d;
        logic [CHAR_W-1:0]  run [$];
        logic [CHAR_W-1:0]  fill_char;
        int                 n_digits;
        int                 pad_len;
        int                 n_out;
        int                 i;
        bit                 neg;
        text_char_t         tc;
        neg      = 1'b0;
        n_digits = 0;
        pad_len  = 0;
        case (fmt_cfg.conversion)
            CONV_OCT: radix = 64'd8;
            CONV_HEX: radix = 64'd16;
            CONV_BIN: radix = 64'd2;
            default:  radix = 64'd10;
        endcase
        mag = fmt_cfg.wide_value ? raw : {32'd0, raw[HALF_W-1:0]};
        if (fmt_cfg.conversion == CONV_SDEC &&
            (fmt_cfg.wide_value ? mag[VALUE_W-1] : mag[HALF_W-1])) begin
            neg = 1'b1;
            if (!fmt_cfg.wide_value) mag[VALUE_W-1:HALF_W] = '1;
            mag = 64'd0 - mag;
        end
        do begin
            digit_buf[n_digits] = DIGIT_W'(mag % radix);
            mag = mag / radix;
            n_digits++;
        end while (mag != 0 && n_digits < DIGIT_LIMIT);

        if (neg) run.push_back(CH_MINUS);
        else if (fmt_cfg.sign_mode == SIGN_PLUS) run.push_back(CH_PLUS);
        else if (fmt_cfg.sign_mode == SIGN_SPACE) run.push_back(CH_SPACE);

        if (fmt_cfg.show_prefix) begin
            if (radix == 64'd8 || radix == 64'd16) begin
                run.push_back(CH_ZERO);
                if (radix == 64'd16) run.push_back(fmt_cfg.upper_hex ? CH_UPPER_X : CH_LOWER_X);
            end else if (radix == 64'd2) begin
                run.push_back(CH_LOWER_B);
            end
        end

        if (int'(fmt_cfg.width_min) > n_digits) pad_len = int'(fmt_cfg.width_min) - n_digits;
        fill_char = fmt_cfg.pad_zero ? CH_ZERO : CH_SPACE;
        if (fmt_cfg.pad_before) repeat (pad_len) run.push_back(fill_char);
        for (i = n_digits - 1; i >= 0; i--) begin
            d = digit_buf[i];
            if (d < 4'd10) run.push_back(CH_ZERO + {4'd0, d});
            else run.push_back((fmt_cfg.upper_hex ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d} - 8'd10);
        end
        if (!fmt_cfg.pad_before) repeat (pad_len) run.push_back(fill_char);

        // Characters past the output limit are dropped; last marks the final one kept.
        n_out = (run.size() > TEXT_LIMIT) ? TEXT_LIMIT : run.size();
        for (i = 0; i < n_out; i++) begin
            tc.character = run[i];
            tc.last      = (i == n_out - 1);
            expected_text.push_back(tc);
        end
    endtask

    // Offers one value and waits for the transaction. Called at a rising edge;
    // valid is left high so that a following call can go back to back.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        predict_text(v);
    endtask

    // Stops offering and waits until every queued character has arrived.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic write_cfg(input itf_cfg_t c);
        write_reg(REG_CONVERSION,  CFG_DATA_W'(c.conversion));
        write_reg(REG_WIDE_VALUE,  CFG_DATA_W'(c.wide_value));
        write_reg(REG_SIGN_MODE,   CFG_DATA_W'(c.sign_mode));
        write_reg(REG_PAD_ZERO,    CFG_DATA_W'(c.pad_zero));
        write_reg(REG_PAD_BEFORE,  CFG_DATA_W'(c.pad_before));
        write_reg(REG_SHOW_PREFIX, CFG_DATA_W'(c.show_prefix));
        write_reg(REG_UPPER_HEX,   CFG_DATA_W'(c.upper_hex));
        write_reg(REG_WIDTH_MIN,   CFG_DATA_W'(c.width_min));
        cfg_wr_en <= 1'b0;
        fmt_cfg = c;
    endtask

    function automatic itf_cfg_t make_cfg(input logic [2:0] conv, input logic wide,
                                          input logic [1:0] sign, input logic zpad,
                                          input logic pad_first, input logic prefix,
                                          input logic upper, input logic [FW_W-1:0] fw);
        itf_cfg_t c;
        c.conversion  = conv;
        c.wide_value  = wide;
        c.sign_mode   = sign;
        c.pad_zero    = zpad;
        c.pad_before  = pad_first;
        c.show_prefix = prefix;
        c.upper_hex   = upper;
        c.width_min   = fw;
        return c;
    endfunction

    function automatic itf_cfg_t random_cfg();
        logic [FW_W-1:0] fw;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: fw = FW_W'($urandom_range(0, 12));
            6, 7:             fw = FW_W'($urandom_range(13, 40));
            8:                fw = FW_W'(TEXT_LIMIT);
            default:          fw = FW_W'($urandom_range(65, 127));
        endcase
        return make_cfg(3'($urandom_range(0, 7)), 1'($urandom), 2'($urandom_range(0, 3)),
                        1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), fw);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 20));
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return '1 - 64'($urandom_range(0, 20));
            4:       return {$urandom, 32'h8000_0000 ^ 32'($urandom_range(0, 3))};
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_text.size() == 0) begin
                $error("character: expected none, actual 0x%02h", m_character);
                errors++;
            end else begin
                want = expected_text.pop_front();
                if (m_character !== want.character) begin
                    $error("character: expected 0x%02h, actual 0x%02h",
                           want.character, m_character);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    task automatic test_decimal();
        write_cfg(make_cfg(CONV_SDEC, 1'b0, SIGN_NEG_ONLY, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0));
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'h0000_0000_FFFF_FFFF);
        send_value(64'h0000_0000_7FFF_FFFF);
        send_value(64'h0000_0000_8000_0000);
        send_value(64'hDEAD_BEEF_0000_0005);
        wait_idle();
        // A negative value takes the minus sign even in plus mode.
        write_cfg(make_cfg(CONV_SDEC, 1'b1, SIGN_PLUS, 1'b1, 1'b1, 1'b0, 1'b0, 7'd5));
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'd42);
        wait_idle();
        // Unused conversion code behaves as unsigned decimal; no decimal prefix.
        write_cfg(make_cfg(3'd7, 1'b1, SIGN_SPACE, 1'b0, 1'b1, 1'b1, 1'b0, 7'd0));
        send_value('1);
        send_value(64'd0);
        wait_idle();
    endtask

    task automatic test_radix();
        // Unused sign mode behaves as negatives only.
        write_cfg(make_cfg(CONV_OCT, 1'b1, 2'd3, 1'b0, 1'b1, 1'b1, 1'b0, 7'd0));
        send_value('1);
        send_value(64'd8);
        wait_idle();
        write_cfg(make_cfg(CONV_HEX, 1'b0, SIGN_NEG_ONLY, 1'b0, 1'b0, 1'b1, 1'b1, 7'd12));
        send_value(64'hABCD_EF01_2345_6789);
        send_value(64'd0);
        wait_idle();
        // A field width of 64 with sign and prefix overruns the output limit.
        write_cfg(make_cfg(CONV_HEX, 1'b1, SIGN_PLUS, 1'b1, 1'b1, 1'b1, 1'b0, 7'd64));
        send_value(64'd1);
        send_value(64'hFEDC_BA98_7654_3210);
        wait_idle();
        write_cfg(make_cfg(CONV_BIN, 1'b1, SIGN_PLUS, 1'b0, 1'b1, 1'b1, 1'b0, 7'd0));
        send_value('1);
        send_value(64'd5);
        wait_idle();
        write_cfg(make_cfg(CONV_BIN, 1'b0, SIGN_SPACE, 1'b1, 1'b0, 1'b0, 1'b1, 7'd127));
        send_value(64'hFFFF_FFFF_0000_0003);
        wait_idle();
    endtask

    task automatic test_random(input int n_phases, input int per_phase);
        repeat (n_phases) begin
            write_cfg(random_cfg());
            repeat (per_phase) send_value(random_value());
            wait_idle();
        end
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        write_cfg(random_cfg());
        repeat (30) send_value(random_value());
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        write_cfg(make_cfg(CONV_SDEC, 1'b1, SIGN_PLUS, 1'b0, 1'b1, 1'b0, 1'b0, 7'd3));
        hold_req++;
        repeat (12) send_value(random_value());
        wait_idle();
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_decimal();
        test_radix();
        test_random(8, 15);
        test_streaming();
        test_backpressure();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_text.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
